FILE: src/tstm_pkg.sv
package tstm_pkg;

    // Characters that the parser recognizes.
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;

    localparam int unsigned MAX_COLONS      = 2;
    localparam int unsigned FRACTION_DIGITS = 3;

    // Scale factors from each field to milliseconds.
    localparam logic [31:0] MS_PER_SECOND = 32'd1000;
    localparam logic [31:0] MS_PER_MINUTE = 32'd60000;
    localparam logic [31:0] MS_PER_HOUR   = 32'd3600000;
    localparam logic [31:0] FIELD_LIMIT   = 32'd60;

    // Parser state as it stands when the terminator arrives.
    typedef struct packed {
        logic [31:0] seconds_acc;
        logic [31:0] minutes_acc;
        logic [31:0] hours_acc;
        logic [9:0]  fraction_ms;
        logic [1:0]  colons_seen;
        logic        error_seen;
    } time_fields_t;

endpackage

FILE: src/tstm_parser.sv
module tstm_parser
    import tstm_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         accept,
    input  logic [7:0]   ch,
    input  logic         last,
    output time_fields_t fields
);

    logic [31:0] seconds_acc_reg, seconds_acc_next;
    logic [31:0] minutes_acc_reg, minutes_acc_next;
    logic [31:0] hours_acc_reg, hours_acc_next;
    logic [9:0]  fraction_ms_reg, fraction_ms_next;
    logic [1:0]  fraction_digits_reg, fraction_digits_next;
    logic [1:0]  colons_seen_reg, colons_seen_next;
    logic        in_fraction_reg, in_fraction_next;
    logic        error_seen_reg, error_seen_next;

    logic [3:0]  digit;
    logic [35:0] acc_wide;
    logic [31:0] acc_sat;
    logic [9:0]  frac_add;

    assign digit    = 4'(ch - CHAR_ZERO);
    // acc * 10 + digit, formed as two shifts and two adds.
    assign acc_wide = ({4'b0, seconds_acc_reg} << 3) + ({4'b0, seconds_acc_reg} << 1)
                    + {32'b0, digit};
    assign acc_sat  = (acc_wide[35:32] != 4'b0) ? 32'hFFFF_FFFF : acc_wide[31:0];

    always_comb
    begin
        case (fraction_digits_reg)
            2'd0:    frac_add = 10'(digit) * 10'd100;
            2'd1:    frac_add = 10'(digit) * 10'd10;
            2'd2:    frac_add = 10'(digit);
            default: frac_add = 10'd0;
        endcase
    end

    always_comb
    begin
        seconds_acc_next     = seconds_acc_reg;
        minutes_acc_next     = minutes_acc_reg;
        hours_acc_next       = hours_acc_reg;
        fraction_ms_next     = fraction_ms_reg;
        fraction_digits_next = fraction_digits_reg;
        colons_seen_next     = colons_seen_reg;
        in_fraction_next     = in_fraction_reg;
        error_seen_next      = error_seen_reg;

        if (accept)
        begin
            if (last)
            begin
                // The terminator ends the string; start fresh for the next one.
                seconds_acc_next     = '0;
                minutes_acc_next     = '0;
                hours_acc_next       = '0;
                fraction_ms_next     = '0;
                fraction_digits_next = '0;
                colons_seen_next     = '0;
                in_fraction_next     = 1'b0;
                error_seen_next      = 1'b0;
            end
            else if (!error_seen_reg)
            begin
                if (ch inside {[CHAR_ZERO:CHAR_NINE]})
                begin
                    if (in_fraction_reg)
                    begin
                        fraction_ms_next = fraction_ms_reg + frac_add;
                        if (fraction_digits_reg < 2'(FRACTION_DIGITS))
                        begin
                            fraction_digits_next = fraction_digits_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        seconds_acc_next = acc_sat;
                    end
                end
                else if (ch == CHAR_COLON)
                begin
                    if (in_fraction_reg || (colons_seen_reg >= 2'(MAX_COLONS)))
                    begin
                        error_seen_next = 1'b1;
                    end
                    else
                    begin
                        hours_acc_next   = minutes_acc_reg;
                        minutes_acc_next = seconds_acc_reg;
                        seconds_acc_next = '0;
                        colons_seen_next = colons_seen_reg + 2'd1;
                    end
                end
                else if (ch inside {CHAR_DOT, CHAR_COMMA})
                begin
                    if (in_fraction_reg)
                    begin
                        error_seen_next = 1'b1;
                    end
                    else
                    begin
                        in_fraction_next = 1'b1;
                    end
                end
                else
                begin
                    error_seen_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seconds_acc_reg     <= '0;
            minutes_acc_reg     <= '0;
            hours_acc_reg       <= '0;
            fraction_ms_reg     <= '0;
            fraction_digits_reg <= '0;
            colons_seen_reg     <= '0;
            in_fraction_reg     <= 1'b0;
            error_seen_reg      <= 1'b0;
        end
        else
        begin
            seconds_acc_reg     <= seconds_acc_next;
            minutes_acc_reg     <= minutes_acc_next;
            hours_acc_reg       <= hours_acc_next;
            fraction_ms_reg     <= fraction_ms_next;
            fraction_digits_reg <= fraction_digits_next;
            colons_seen_reg     <= colons_seen_next;
            in_fraction_reg     <= in_fraction_next;
            error_seen_reg      <= error_seen_next;
        end
    end

    assign fields.seconds_acc = seconds_acc_reg;
    assign fields.minutes_acc = minutes_acc_reg;
    assign fields.hours_acc   = hours_acc_reg;
    assign fields.fraction_ms = fraction_ms_reg;
    assign fields.colons_seen = colons_seen_reg;
    assign fields.error_seen  = error_seen_reg;

endmodule

FILE: src/time_string_to_milliseconds.sv
// Channel  | Direction | Payload
// ---------+-----------+--------------------------------------------------
// s_axis   | in        | tdata[7:0] = ch, tlast = terminator
// m_axis   | out       | tdata[31:0] = time_ms, tuser[0] = bad_format
//
// One character transaction is taken every cycle unless the input stalls;
// the parser state register updates in the accepting cycle. A terminator's
// result passes through a product stage and then the output register.
// Reset clears the parser state and both valid flags.
// The input stalls only when the product stage holds a terminator that the
// output register cannot yet take.
module time_string_to_milliseconds
    import tstm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tlast,   // terminator item

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] time_ms
    output logic        m_tuser    // [0] bad_format
);

    time_fields_t fields;
    logic         in_accept;
    logic         out_free;

    // Product stage: each field scaled to milliseconds, modulo 2^32.
    logic        prod_valid_reg, prod_valid_next;
    logic [31:0] sec_ms_reg, sec_ms_next;
    logic [31:0] min_ms_reg, min_ms_next;
    logic [31:0] hrs_ms_reg, hrs_ms_next;
    logic        prod_bad_reg, prod_bad_next;

    // Output register.
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_ms_reg, out_ms_next;
    logic        out_bad_reg, out_bad_next;

    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = !prod_valid_reg || out_free;
    assign in_accept = s_tvalid && s_tready;

    tstm_parser u_parser
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (in_accept),
        .ch     (s_tdata),
        .last   (s_tlast),
        .fields (fields)
    );

    always_comb
    begin
        // The terminator captures the fields as they stand before it.
        sec_ms_next = fields.seconds_acc * MS_PER_SECOND + 32'(fields.fraction_ms);
        min_ms_next = fields.minutes_acc * MS_PER_MINUTE;
        hrs_ms_next = fields.hours_acc * MS_PER_HOUR;
        // Minutes are only range checked once a colon has made them a field.
        prod_bad_next = fields.error_seen
                     || (fields.seconds_acc >= FIELD_LIMIT)
                     || ((fields.colons_seen != 2'd0) && (fields.minutes_acc >= FIELD_LIMIT));

        prod_valid_next = prod_valid_reg;
        if (in_accept && s_tlast)
        begin
            prod_valid_next = 1'b1;
        end
        else if (out_free)
        begin
            prod_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        out_ms_next    = out_ms_reg;
        out_bad_next   = out_bad_reg;
        if (out_free)
        begin
            out_valid_next = prod_valid_reg;
            out_ms_next    = prod_bad_reg ? 32'd0 : (sec_ms_reg + min_ms_reg + hrs_ms_reg);
            out_bad_next   = prod_bad_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= prod_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && s_tlast)
        begin
            sec_ms_reg   <= sec_ms_next;
            min_ms_reg   <= min_ms_next;
            hrs_ms_reg   <= hrs_ms_next;
            prod_bad_reg <= prod_bad_next;
        end
        out_ms_reg  <= out_ms_next;
        out_bad_reg <= out_bad_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_ms_reg;
    assign m_tuser  = out_bad_reg;

endmodule

FILE: verif/time_string_to_milliseconds_test.sv
module time_string_to_milliseconds_test
    import tstm_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // The run is stopped by force after this many clock cycles. The slowest
    // correct run is roughly 1900 transactions.
    localparam int unsigned CYCLE_LIMIT  = 500000;
    localparam int unsigned RANDOM_ITEMS = 1850;
    localparam int unsigned MAX_WAIT     = 18;

    // Tracks the parser state and the durations still owed by the block.
    class duration_scoreboard;
        typedef struct {
            logic [31:0] time_ms;
            logic        bad_format;
        } duration_t;

        duration_t   expected_durations[$];
        logic [31:0] seconds_acc;
        logic [31:0] minutes_acc;
        logic [31:0] hours_acc;
        logic [9:0]  fraction_ms;
        logic [1:0]  fraction_digits;
        logic [1:0]  colons_seen;
        logic        in_fraction;
        logic        error_seen;
        int unsigned failures;

        function new();
            failures = 0;
            clear_fields();
        endfunction

        function void clear_fields();
            seconds_acc     = '0;
            minutes_acc     = '0;
            hours_acc       = '0;
            fraction_ms     = '0;
            fraction_digits = '0;
            colons_seen     = '0;
            in_fraction     = 1'b0;
            error_seen      = 1'b0;
        endfunction

        function int unsigned pending();
            return expected_durations.size();
        endfunction

        // Updates the parser state with one accepted character transaction.
        // The terminator closes the string and queues its duration.
        function void note_char(logic [7:0] ch, logic last);
            duration_t        owed;
            logic [31:0]      total;
            logic [3:0]       digit;
            longint unsigned  widened;

            if (last)
            begin
                owed.bad_format = error_seen;
                if (seconds_acc >= FIELD_LIMIT)
                    owed.bad_format = 1'b1;
                if (colons_seen != 0 && minutes_acc >= FIELD_LIMIT)
                    owed.bad_format = 1'b1;
                // All products and the sum wrap at 32 bits.
                total = seconds_acc * MS_PER_SECOND + 32'(fraction_ms)
                      + minutes_acc * MS_PER_MINUTE + hours_acc * MS_PER_HOUR;
                owed.time_ms = owed.bad_format ? 32'd0 : total;
                expected_durations.push_back(owed);
                clear_fields();
                return;
            end

            // Once rejected, the rest of the string is ignored.
            if (error_seen)
                return;

            if (ch >= CHAR_ZERO && ch <= CHAR_NINE)
            begin
                digit = 4'(ch - CHAR_ZERO);
                if (in_fraction)
                begin
                    // Only the first three fraction digits count.
                    case (fraction_digits)
                        2'd0: fraction_ms = fraction_ms + 10'(digit) * 10'd100;
                        2'd1: fraction_ms = fraction_ms + 10'(digit) * 10'd10;
                        2'd2: fraction_ms = fraction_ms + 10'(digit);
                        default: ;
                    endcase
                    if (fraction_digits < 2'(FRACTION_DIGITS))
                        fraction_digits = fraction_digits + 2'd1;
                end
                else
                begin
                    // The current field saturates instead of wrapping.
                    widened = longint'(seconds_acc) * 10 + longint'(digit);
                    seconds_acc = (widened > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                             : 32'(widened);
                end
            end
            else if (ch == CHAR_COLON)
            begin
                if (in_fraction || colons_seen >= 2'(MAX_COLONS))
                    error_seen = 1'b1;
                else
                begin
                    hours_acc   = minutes_acc;
                    minutes_acc = seconds_acc;
                    seconds_acc = '0;
                    colons_seen = colons_seen + 2'd1;
                end
            end
            else if (ch == CHAR_DOT || ch == CHAR_COMMA)
            begin
                if (in_fraction)
                    error_seen = 1'b1;
                else
                    in_fraction = 1'b1;
            end
            else
                error_seen = 1'b1;
        endfunction

        // Compares one result transaction with the oldest owed duration.
        function void check_duration(logic [31:0] time_ms, logic bad_format);
            duration_t owed;

            if (expected_durations.size() == 0)
            begin
                $error("time_ms: no result expected, got %0d (bad_format %0b)",
                       time_ms, bad_format);
                failures++;
                return;
            end
            owed = expected_durations.pop_front();
            if (time_ms !== owed.time_ms)
            begin
                $error("time_ms: expected %0d, actual %0d", owed.time_ms, time_ms);
                failures++;
            end
            if (bad_format !== owed.bad_format)
            begin
                $error("bad_format: expected %0b, actual %0b",
                       owed.bad_format, bad_format);
                failures++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;

    duration_scoreboard track = new();

    // Characters of the string being built, sent ahead of its terminator.
    logic [7:0]  text[$];
    int unsigned items_sent = 0;
    int unsigned cycles = 0;
    // Remaining transactions in a stretch without idle cycles, per side.
    int unsigned send_quiet = 0;
    int unsigned recv_quiet = 0;

    time_string_to_milliseconds dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("FAIL time_string_to_milliseconds");
            $finish;
        end
    end

    // Draws the idle time before the next transaction. Now and then a side
    // enters a stretch with no idling at all, so back-to-back traffic is
    // exercised as well as gaps at every phase.
    function automatic int unsigned draw_wait(ref int unsigned quiet);
        if (quiet != 0)
        begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
            quiet = $urandom_range(5, 40);
        return $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic void push_decimal(int unsigned value, int unsigned width);
        logic [7:0] digits[$];

        do
        begin
            digits.push_front(CHAR_ZERO + 8'(value % 10));
            value /= 10;
        end while (value != 0);
        while (digits.size() < width)
            digits.push_front(CHAR_ZERO);
        foreach (digits[i])
            text.push_back(digits[i]);
    endfunction

    function automatic void push_digits(int unsigned count);
        repeat (count)
            text.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
    endfunction

    function automatic void push_string(string s);
        for (int i = 0; i < s.len(); i++)
            text.push_back(8'(s[i]));
    endfunction

    // A minutes or seconds field: mostly in range, sometimes empty, sometimes
    // right at or beyond the limit of 60.
    function automatic void push_field();
        int unsigned pick;

        pick = $urandom_range(0, 19);
        if (pick == 0)
            return;
        else if (pick == 1)
            push_decimal($urandom_range(60, 999), 0);
        else if (pick == 2)
            push_decimal($urandom_range(59, 60), 2);
        else
            push_decimal($urandom_range(0, 59), $urandom_range(1, 3));
    endfunction

    // A well-formed string with random content. Long hour fields reach the
    // saturation of the digit accumulator and the 32-bit wrap of the total.
    function automatic void build_valid_text();
        int unsigned colons;

        colons = $urandom_range(0, 2);
        if (colons == 2)
        begin
            case ($urandom_range(0, 7))
                0: push_digits($urandom_range(8, 12));
                1: ;
                default: push_decimal($urandom_range(0, 1200), $urandom_range(1, 2));
            endcase
            text.push_back(CHAR_COLON);
        end
        if (colons >= 1)
        begin
            push_field();
            text.push_back(CHAR_COLON);
        end
        push_field();
        if ($urandom_range(0, 1) == 1)
        begin
            text.push_back($urandom_range(0, 1) ? CHAR_DOT : CHAR_COMMA);
            push_digits($urandom_range(0, 5));
        end
    endfunction

    // Sends one character transaction after a random idle time.
    task automatic send_item(logic [7:0] ch, logic last);
        int unsigned gap;

        gap = draw_wait(send_quiet);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        track.note_char(ch, last);
        items_sent++;
    endtask

    // Sends the characters held in text, then the terminator. The terminator
    // usually carries character 0, but its character is ignored, so any
    // value is legal there.
    task automatic send_text();
        foreach (text[i])
            send_item(text[i], 1'b0);
        send_item(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : 8'd0,
                  1'b1);
        text.delete();
    endtask

    // Result side: the ready line idles at random, and every accepted result
    // transaction is checked against the oldest owed duration.
    initial
    begin
        int unsigned gap;

        @(posedge rst_n);
        forever
        begin
            gap = draw_wait(recv_quiet);
            if (gap != 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            track.check_duration(m_tdata, m_tuser);
        end
    end

    initial
    begin
        int unsigned pick;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed strings. The empty string counts as zero.
        send_text();
        // Seconds at the limit.
        push_string("60");
        send_text();
        // A third colon.
        push_string(":::");
        send_text();
        // A second decimal separator.
        push_string(".,");
        send_text();
        // The highest character code, which is not allowed.
        text.push_back(8'hFF);
        send_text();
        // A zero character that is not marked as the terminator.
        text.push_back(8'h00);
        send_text();
        // Minutes at the limit once a colon was seen.
        push_string("60:0");
        send_text();
        // Comma as separator, with a fourth fraction digit that is dropped.
        push_string("9,1239");
        send_text();

        // Random strings: mostly well-formed, some with one stray character
        // inserted, and some pure noise over the whole character range.
        while (items_sent < RANDOM_ITEMS)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 14)
                build_valid_text();
            else if (pick < 17)
            begin
                build_valid_text();
                case ($urandom_range(0, 4))
                    0: text.insert($urandom_range(0, text.size()), CHAR_COLON);
                    1: text.insert($urandom_range(0, text.size()), CHAR_DOT);
                    2: text.insert($urandom_range(0, text.size()), CHAR_COMMA);
                    3: text.insert($urandom_range(0, text.size()), 8'h00);
                    default: text.insert($urandom_range(0, text.size()),
                                         8'($urandom_range(0, 255)));
                endcase
            end
            else
                repeat ($urandom_range(1, 6))
                    text.push_back(8'($urandom_range(0, 255)));
            send_text();
        end

        // The last terminator was taken at this edge; drop valid before the
        // next one so that it is not sent twice.
        s_tvalid <= 1'b0;

        // Drain the owed results, then allow a few more cycles so that a
        // spurious extra result would still be caught.
        while (track.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (track.failures == 0)
            $display("PASS time_string_to_milliseconds");
        else
            $display("FAIL time_string_to_milliseconds");
        $finish;
    end

endmodule

FILE: filelist.f
src/tstm_pkg.sv
src/tstm_parser.sv
src/time_string_to_milliseconds.sv
verif/time_string_to_milliseconds_test.sv
